// ----- src/sia_pkg.sv -----
`default_nettype none
package sia_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_USED   = 3'd3,
    ST_UNUSED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] slot_index;
    logic [63:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] granted_index;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_POP_CHK,
    S_CMP_SCAN,
    S_CMP_WRITE,
    S_PUSH,
    S_RESP
  } state_e;

endpackage
`default_nettype wire

// ----- src/sia_stack.sv -----
`default_nettype none
module sia_stack #(
  parameter int unsigned Entries = 256,
  parameter int unsigned IdxW    = 8
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [IdxW-1:0] wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output logic      [IdxW-1:0] rdata_o
);
  logic [IdxW-1:0] mem [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- src/sia_values.sv -----
`default_nettype none
module sia_values #(
  parameter int unsigned Entries = 256,
  parameter int unsigned IdxW    = 8
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [63:0]     wdata_i
);
  logic [63:0] mem [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

// ----- src/slot_index_allocator_top.sv -----
`default_nettype none
// Slot index allocator: add, insert and remove requests over a table of
// TABLE_ENTRIES slots, one request at a time with one response each. The
// response is offered from the response state, entered after the decode
// state (and for add, after the pop states), and the next request is taken
// the cycle after the response is. Add pops free-stack entries, each read
// and then checked (stale entries are skipped); once the stack is empty it
// tries bump-pointer slots in turn, or reports the table full. A remove on a
// full free stack first compacts it with a sweep over all entries, since
// the stack memory has one read port. The in-use bitmap is reset in
// flip-flops; no clearing pass.
module slot_index_allocator_top #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sia_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sia_pkg::rsp_t      out_data_o
);
  import sia_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = IdxW + 1;

  state_e state_q, state_d;
  req_t   req_q;
  logic [TABLE_ENTRIES-1:0] used_q;
  logic [TABLE_ENTRIES-1:0] seen_q;
  logic [CntW-1:0] depth_q, depth_d, bump_q, bump_d, scan_q, scan_d, wcnt_q, wcnt_d;
  logic [2:0]      status_q, status_d;
  logic [IdxW-1:0] grant_q, grant_d;
  logic            out_valid_q;

  logic            st_we;
  logic [IdxW-1:0] st_waddr, st_wdata, st_raddr, st_rdata;
  logic            val_we;
  logic [IdxW-1:0] val_addr;
  logic [63:0]     val_data;
  logic            set_used, clr_used, set_seen, clr_seen;
  logic [IdxW-1:0] used_idx;

  logic            in_range;
  logic [IdxW-1:0] req_idx;

  assign in_range = (32'(req_q.slot_index) < TABLE_ENTRIES);
  assign req_idx  = req_q.slot_index[IdxW-1:0];

  sia_stack #(.Entries(TABLE_ENTRIES), .IdxW(IdxW)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  sia_values #(.Entries(TABLE_ENTRIES), .IdxW(IdxW)) u_values (
    .clk_i, .we_i(val_we), .waddr_i(val_addr), .wdata_i(val_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (kind_e'(req_q.kind))
          KIND_ADD: state_d = S_POP_RD;
          KIND_REMOVE: begin
            if (in_range && used_q[req_idx] && depth_q >= CntW'(TABLE_ENTRIES)) begin
              state_d = S_CMP_SCAN;
            end else begin
              state_d = S_RESP;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_POP_RD: begin
        if (depth_q != '0) state_d = S_POP_CHK;
        else if (bump_q < CntW'(TABLE_ENTRIES) && used_q[bump_q[IdxW-1:0]]) begin
          state_d = S_POP_RD;
        end
        else state_d = S_RESP;
      end
      S_POP_CHK: begin
        if (!used_q[st_rdata]) state_d = S_RESP;
        else state_d = S_POP_RD;
      end
      S_CMP_SCAN:  if (scan_q == depth_q - 1'b1) state_d = S_CMP_WRITE;
      S_CMP_WRITE: if (scan_q == CntW'(TABLE_ENTRIES - 1)) state_d = S_PUSH;
      S_PUSH:      state_d = S_RESP;
      S_RESP:      if (!out_stall_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    depth_d  = depth_q;
    bump_d   = bump_q;
    scan_d   = scan_q;
    wcnt_d   = wcnt_q;
    status_d = status_q;
    grant_d  = grant_q;
    st_we    = 1'b0;
    st_waddr = depth_q[IdxW-1:0];
    st_wdata = req_idx;
    st_raddr = depth_q[IdxW-1:0] - 1'b1;
    val_we   = 1'b0;
    val_addr = req_idx;
    val_data = req_q.entry_value;
    set_used = 1'b0;
    clr_used = 1'b0;
    set_seen = 1'b0;
    clr_seen = 1'b0;
    used_idx = req_idx;
    case (state_q)
      S_IDLE: begin
        status_d = ST_OK;
        grant_d  = '0;
      end
      S_DECODE: begin
        scan_d = '0;
        wcnt_d = '0;
        clr_seen = 1'b1;
        case (kind_e'(req_q.kind))
          KIND_INSERT: begin
            if (!in_range) status_d = ST_RANGE;
            else if (used_q[req_idx]) status_d = ST_USED;
            else begin
              set_used = 1'b1;
              val_we   = 1'b1;
            end
          end
          KIND_REMOVE: begin
            if (!in_range) status_d = ST_RANGE;
            else if (!used_q[req_idx]) status_d = ST_UNUSED;
            else begin
              clr_used = 1'b1;
              val_we   = 1'b1;
              val_data = '0;
              if (depth_q < CntW'(TABLE_ENTRIES)) begin
                st_we   = 1'b1;
                depth_d = depth_q + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_POP_RD: begin
        if (depth_q != '0) begin
          depth_d = depth_q - 1'b1;
        end else if (bump_q < CntW'(TABLE_ENTRIES)) begin
          bump_d = bump_q + 1'b1;
          if (!used_q[bump_q[IdxW-1:0]]) begin
            grant_d  = bump_q[IdxW-1:0];
            used_idx = bump_q[IdxW-1:0];
            set_used = 1'b1;
            val_we   = 1'b1;
            val_addr = bump_q[IdxW-1:0];
          end
        end else begin
          status_d = ST_FULL;
        end
      end
      S_POP_CHK: begin
        used_idx = st_rdata;
        if (!used_q[st_rdata]) begin
          grant_d  = st_rdata;
          set_used = 1'b1;
          val_we   = 1'b1;
          val_addr = st_rdata;
        end
      end
      S_CMP_SCAN: begin
        st_raddr = scan_q[IdxW-1:0];
        scan_d   = scan_q + 1'b1;
        if (scan_q != '0) begin
          used_idx = st_rdata;
          set_seen = 1'b1;
        end
        if (scan_q == depth_q - 1'b1) scan_d = '0;
      end
      S_CMP_WRITE: begin
        if (scan_q == '0) begin
          used_idx = st_rdata;
          set_seen = 1'b1;
        end
        scan_d = scan_q + 1'b1;
        if (seen_q[scan_q[IdxW-1:0]] ||
            (scan_q == '0 && st_rdata == '0)) begin
          st_we    = 1'b1;
          st_waddr = wcnt_q[IdxW-1:0];
          st_wdata = scan_q[IdxW-1:0];
          wcnt_d   = wcnt_q + 1'b1;
        end
      end
      S_PUSH: begin
        depth_d  = wcnt_q;
        clr_used = 1'b1;
        val_we   = 1'b1;
        val_data = '0;
        if (wcnt_q < CntW'(TABLE_ENTRIES)) begin
          st_we    = 1'b1;
          st_waddr = wcnt_q[IdxW-1:0];
          depth_d  = wcnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      seen_q      <= '0;
      depth_q     <= '0;
      bump_q      <= '0;
      scan_q      <= '0;
      wcnt_q      <= '0;
      status_q    <= ST_OK;
      grant_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      bump_q   <= bump_d;
      scan_q   <= scan_d;
      wcnt_q   <= wcnt_d;
      status_q <= status_d;
      grant_q  <= grant_d;
      if (set_used) used_q[used_idx] <= 1'b1;
      if (clr_used) used_q[req_idx]  <= 1'b0;
      if (clr_seen) seen_q <= '0;
      else if (set_seen) seen_q[used_idx] <= 1'b1;
      if (state_d == S_RESP && state_q != S_RESP) out_valid_q <= 1'b1;
      else if (state_q == S_RESP && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  assign in_stall_o               = (state_q != S_IDLE);
  assign out_valid_o              = out_valid_q;
  assign out_data_o.status        = status_q;
  assign out_data_o.granted_index = grant_q;
endmodule
`default_nettype wire

// ----- src/sia_checker.sv -----
`default_nettype none
module sia_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire sia_pkg::req_t in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire sia_pkg::rsp_t out_data_o
);
  import sia_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response changed");

  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while response pending");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_UNUSED)
    else $error("bad status");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.granted_index == '0)
    else $error("grant on failure");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("ready right after accept");
endmodule

bind slot_index_allocator_top sia_checker u_sia_checker (.*);
`default_nettype wire
